/* hw/rtl/fpha_pkg.sv */
// ----------------------------------------------------------------------------
// fpha_pkg
// shared types and codes for the fit-policy heap allocator
// ----------------------------------------------------------------------------
package fpha_pkg;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [1:0] CFG_HEAP_BYTES = 2'd1;

  localparam int CFG_DATA_BITS = 17;

  typedef struct packed {
    logic        func;
    logic [15:0] req_size;
    logic [15:0] free_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block_id;
    logic [15:0] data_offset;
    logic [15:0] alloc_attempts;
    logic [15:0] alloc_failures;
  } rsp_t;

endpackage

/* hw/rtl/fpha_ram.sv */
// ----------------------------------------------------------------------------
// fpha_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module fpha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/fit_policy_heap_allocator_top.sv */
// ----------------------------------------------------------------------------
// fit_policy_heap_allocator_top
// heap segment allocator with first, best and worst fit and coalescing free
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data): one transfer is one request,
//   allocate (func 0) or free by id (func 1)
//   out channel (out_valid/out_ready/out_data): exactly one result transfer
//   per request, in request order
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 fit policy,
//   index 1 heap size; a heap size write rebuilds the table as one free
//   segment and clears the id and statistics counters
// table updates
//   the segment table lives in one ram with one read and one write port;
//   a sequencer scans it one entry per cycle and moves entries one per cycle
//   allocate: scan for a free entry that fits; a split moves the entries
//   after the chosen one up by one; free: scan up to the matching id, and a
//   merge moves the later entries down; in_ready is low meanwhile
// reset
//   synchronous rst; the first cycle after reset writes segment 0
// stalls
//   the result sits in an output register; a new request is taken while it
//   waits, and its result is held back until the old one is transferred
module fit_policy_heap_allocator_top #(
  parameter int MAX_SEGMENTS = 64,
  parameter int HEADER_BYTES = 40,
  parameter int ADDR_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  fpha_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output fpha_pkg::rsp_t                    out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [fpha_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  // widths
  localparam int IW = $clog2(MAX_SEGMENTS);      // table index
  localparam int CW = IW + 1;                    // count, holds MAX_SEGMENTS
  localparam int SW = ADDR_BITS + 1;             // segment size
  localparam int XW = ((SW > 17) ? SW : 17) + 1; // arithmetic width

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
  localparam logic [XW-1:0] HDR     = XW'(HEADER_BYTES);
  localparam logic [XW-1:0] HEAP_LO = XW'(HEADER_BYTES + 1);
  localparam logic [XW-1:0] HEAP_HI = XW'(1) << ADDR_BITS;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SW-1:0]        size;
    logic                 used;
    logic [15:0]          id;
  } seg_t;

  localparam int EW = $bits(seg_t);

  typedef enum logic [7:0] {
    S_INIT = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_SCAN = 8'b0000_0100,
    S_ADEC = 8'b0000_1000,
    S_FRNB = 8'b0001_0000,
    S_COPY = 8'b0010_0000,
    S_WRB  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration
  logic [1:0]  policy;
  logic [16:0] heap;

  // request and table bookkeeping
  logic        is_free;
  logic [15:0] req;
  logic [15:0] fid;
  logic [CW-1:0] cnt;
  logic [15:0] next_id;
  logic [15:0] att;
  logic [15:0] fail;

  // scan pipeline
  logic [CW-1:0] ra;   // next read index
  logic          dv;   // ram data valid
  logic [CW-1:0] di;   // index of ram data
  logic          found;
  logic [CW-1:0] t;    // chosen or matched index
  seg_t          tseg; // chosen or matched entry
  seg_t          prev; // entry before the one under test

  // move engine
  logic [CW-1:0] cs;   // source index
  logic [CW-1:0] cn;   // moves left
  logic          cup;  // move upward
  logic [1:0]    cd;   // downward distance
  logic          pv;
  logic [CW-1:0] pa;
  logic          split;

  // result
  logic [1:0]  res_status;
  logic [15:0] res_id;
  logic [15:0] res_off;

  // ram ports
  logic          we;
  logic [IW-1:0] waddr;
  seg_t          wdata;
  logic [IW-1:0] raddr;
  logic [EW-1:0] rraw;
  seg_t          rdata;

  fpha_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rraw)
  );

  assign rdata = seg_t'(rraw);

  // a register write takes priority over a request in the same cycle
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);

  // heap clamp for table rebuild
  logic [XW-1:0] heap_x;
  logic [XW-1:0] heap_c;
  assign heap_x = XW'(heap);
  assign heap_c = (heap_x < HEAP_LO) ? HEAP_LO : ((heap_x > HEAP_HI) ? HEAP_HI : heap_x);

  // scan compare
  logic [XW-1:0] r_size;
  logic [XW-1:0] t_size;
  logic [XW-1:0] req_x;
  logic          cand;
  logic          better;
  logic          stop_first;
  logic          last;
  logic          match;
  assign r_size     = XW'(rdata.size);
  assign t_size     = XW'(tseg.size);
  assign req_x      = XW'(req);
  assign cand       = !rdata.used && (r_size >= req_x);
  assign stop_first = (policy != fpha_pkg::POL_BEST) && (policy != fpha_pkg::POL_WORST);
  assign better     = !found
                      || ((policy == fpha_pkg::POL_BEST)  && (r_size < t_size))
                      || ((policy == fpha_pkg::POL_WORST) && (r_size > t_size));
  assign last       = (di == cnt - CW'(1));
  assign match      = rdata.used && (rdata.id == fid);

  // allocation arithmetic
  logic [XW-1:0] start_x;
  logic [XW-1:0] off_x;
  logic [XW-1:0] new_start;
  logic [XW-1:0] new_size;
  assign start_x   = XW'(tseg.start);
  assign off_x     = start_x + HDR;
  assign new_start = off_x + req_x;
  assign new_size  = t_size - req_x - HDR;

  // free merge: tseg is the freed entry, rdata its right neighbor
  logic          has_right;
  logic          mr;
  logic          ml;
  logic [XW-1:0] m_size;
  logic [XW-1:0] l_size;
  assign has_right = (t + CW'(1) < cnt);
  assign mr        = has_right && !rdata.used;
  assign ml        = (t != '0) && !prev.used;
  assign m_size    = t_size + (mr ? (HDR + r_size) : '0);
  assign l_size    = XW'(prev.size) + HDR + m_size;

  // ram address and write mux
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (state)
      S_INIT: begin
        we         = 1'b1;
        wdata.size = SW'(heap_c - HDR);
      end
      S_SCAN: begin
        raddr = ra[IW-1:0];
      end
      S_FRNB: begin
        we = 1'b1;
        if (ml) begin
          waddr       = IW'(t - CW'(1));
          wdata.start = prev.start;
          wdata.size  = SW'(l_size);
        end else begin
          waddr       = t[IW-1:0];
          wdata.start = tseg.start;
          wdata.size  = SW'(m_size);
        end
      end
      S_COPY: begin
        raddr = cs[IW-1:0];
        we    = pv;
        waddr = cup ? IW'(pa + CW'(1)) : IW'(pa - CW'(cd));
        wdata = rdata;
      end
      S_WRB: begin
        // new free tail of a split
        we          = 1'b1;
        waddr       = IW'(t + CW'(1));
        wdata.start = ADDR_BITS'(new_start);
        wdata.size  = SW'(new_size);
      end
      S_DONE: begin
        // allocated entry, written in the result state before leaving
        we         = !is_free && (res_status == fpha_pkg::ST_ALLOCATED);
        waddr      = t[IW-1:0];
        wdata      = tseg;
        wdata.used = 1'b1;
        wdata.id   = res_id;
        if (split) begin
          wdata.size = SW'(req);
        end
      end
      S_IDLE, S_ADEC: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      policy    <= fpha_pkg::POL_FIRST;
      heap      <= 17'h10000;
      cnt       <= CW'(1);
      next_id   <= 16'd1;
      att       <= '0;
      fail      <= '0;
      out_valid <= 1'b0;
      dv        <= 1'b0;
      pv        <= 1'b0;
      found     <= 1'b0;
    end else begin
      // the result state loads a new result itself when the old one leaves
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          cnt     <= CW'(1);
          next_id <= 16'd1;
          att     <= '0;
          fail    <= '0;
          state   <= S_IDLE;
        end
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == fpha_pkg::CFG_FIT_POLICY) begin
              policy <= cfg_data[1:0];
            end else if (cfg_index == fpha_pkg::CFG_HEAP_BYTES) begin
              heap  <= cfg_data;
              state <= S_INIT;
            end
          end else if (in_valid) begin
            is_free <= (in_data.func == fpha_pkg::FUNC_FREE);
            req     <= in_data.req_size;
            fid     <= in_data.free_id;
            ra      <= '0;
            dv      <= 1'b0;
            found   <= 1'b0;
            split   <= 1'b0;
            prev    <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ra < cnt) begin
            ra <= ra + CW'(1);
            dv <= 1'b1;
            di <= ra;
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            // keep the left neighbor of a matched entry
            if (!(is_free && match)) begin
              prev <= rdata;
            end
            if (!is_free) begin
              if (cand && better) begin
                t     <= di;
                tseg  <= rdata;
                found <= 1'b1;
              end
              if ((cand && stop_first) || last) begin
                state <= S_ADEC;
              end
            end else if (match) begin
              t     <= di;
              tseg  <= rdata;
              state <= S_FRNB;
            end else if (last) begin
              res_status <= fpha_pkg::ST_NOT_FOUND;
              res_id     <= '0;
              res_off    <= '0;
              state      <= S_DONE;
            end
          end
        end
        S_ADEC: begin
          att <= att + 16'd1;
          if (!found) begin
            fail       <= fail + 16'd1;
            res_status <= fpha_pkg::ST_NO_MEMORY;
            res_id     <= '0;
            res_off    <= '0;
            state      <= S_DONE;
          end else begin
            res_status <= fpha_pkg::ST_ALLOCATED;
            res_id     <= next_id;
            res_off    <= off_x[15:0];
            next_id    <= (next_id == 16'hFFFF) ? 16'd1 : next_id + 16'd1;
            if ((t_size >= req_x + HDR + XW'(1)) && (cnt < MAX_CNT)) begin
              split <= 1'b1;
              cup   <= 1'b1;
              cs    <= cnt - CW'(1);
              cn    <= cnt - CW'(1) - t;
              pv    <= 1'b0;
              cnt   <= cnt + CW'(1);
              state <= S_COPY;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FRNB: begin
          res_status <= fpha_pkg::ST_FREED;
          res_id     <= fid;
          res_off    <= '0;
          cup        <= 1'b0;
          cd         <= {1'b0, mr} + {1'b0, ml};
          cs         <= t + CW'(1) + CW'(mr);
          cn         <= (mr || ml) ? (cnt - t - CW'(1) - CW'(mr)) : '0;
          pv         <= 1'b0;
          cnt        <= cnt - CW'(mr) - CW'(ml);
          state      <= (mr || ml) ? S_COPY : S_DONE;
        end
        S_COPY: begin
          if (cn != '0) begin
            cs <= cup ? cs - CW'(1) : cs + CW'(1);
            cn <= cn - CW'(1);
            pv <= 1'b1;
            pa <= cs;
          end else begin
            pv <= 1'b0;
            if (!pv) begin
              state <= is_free ? S_DONE : S_WRB;
            end
          end
        end
        S_WRB: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.status         <= res_status;
            out_data.block_id       <= res_id;
            out_data.data_offset    <= res_off;
            out_data.alloc_attempts <= att;
            out_data.alloc_failures <= fail;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // segment count always stays within the table
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (cnt <= MAX_CNT))
    else $error("segment count out of range");

  // an accepted request always starts a table scan
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !cfg_valid) |=> (state == S_SCAN))
    else $error("request did not start a scan");

  // a heap size write rebuilds the table next cycle
  a_cfg_init: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == fpha_pkg::CFG_HEAP_BYTES)) |=> (state == S_INIT))
    else $error("heap write did not rebuild the table");

  // table writes only happen in states that own the write port
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state != S_IDLE) && (state != S_SCAN) && (state != S_ADEC))
    else $error("table write outside of an update state");

endmodule
